FILE: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/aes_pkg.sv
package aes_pkg;

    localparam int unsigned NumRounds = 10;

    typedef logic [127:0] block_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } reg_idx_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the state sits at bits 8i+7..8i
    function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
        get_byte = s[8*i +: 8];
    endfunction

endpackage

FILE: design/aes_key_cell.sv
// one key expansion step: round key n in, round key n+1 out
module aes_key_cell (
    input  logic                clk,
    input  logic [7:0]          rcon,
    input  aes_pkg::block_t     key_in,
    output aes_pkg::block_t     key_out
);

    aes_pkg::block_t key_next;

    // word recurrence with rotated, substituted last word
    always_comb
    begin
        logic [31:0] t;
        logic [31:0] w [4];
        t = {aes_pkg::SBOX[key_in[103:96]],
             aes_pkg::SBOX[key_in[127:120]],
             aes_pkg::SBOX[key_in[119:112]],
             aes_pkg::SBOX[key_in[111:104]] ^ rcon};
        w[0] = key_in[31:0] ^ t;
        w[1] = key_in[63:32] ^ w[0];
        w[2] = key_in[95:64] ^ w[1];
        w[3] = key_in[127:96] ^ w[2];
        key_next = {w[3], w[2], w[1], w[0]};
    end

    always_ff @(posedge clk)
    begin
        key_out <= key_next;
    end

endmodule

FILE: design/aes_round_cell.sv
// one cipher round with registered output
module aes_round_cell #(
    parameter bit LastRound = 1'b0
) (
    input  logic                clk,
    input  aes_pkg::block_t     state_in,
    input  aes_pkg::block_t     round_key,
    output aes_pkg::block_t     state_out
);

    aes_pkg::block_t state_next;

    // sub bytes, shift rows, mix columns (skipped in the last round), add round key
    always_comb
    begin
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[4*c+r] = aes_pkg::SBOX[aes_pkg::get_byte(state_in,
                                           unsigned'(4*((c+r)%4)+r))];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (!LastRound)
            begin
                t[4*c]   = a0 ^ all ^ aes_pkg::xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ aes_pkg::xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ aes_pkg::xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ aes_pkg::xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            state_next[8*i +: 8] = t[i] ^ round_key[8*i +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        state_out <= state_next;
    end

endmodule

FILE: design/aes128_encrypt.sv
// AES-128 encryption, fully unrolled round pipeline
// start with busy low moves one plaintext beat in; busy is tied low, so a
// new block may enter in every clock cycle
// the ciphertext appears on cipher_low/cipher_high for one cycle with done
// high, after the initial key add register and then one register per round
// cell; throughput is one block per cycle
// each round cell and its key cell are one pipeline stage; the round key
// travels down the key chain beside its block, so a key write affects only
// blocks started after it
// key registers are written through cfg_we/cfg_index/cfg_data; index 0 is
// key_low, index 1 key_high; cfg_index is one bit and has no other values
// reset clears the keys and the valid chain; blocks in flight are dropped
// the receiver cannot stall: done is a plain strobe
module aes128_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] plain_low,
    input  logic [63:0] plain_high,
    output logic        done,
    output logic [63:0] cipher_low,
    output logic [63:0] cipher_high,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned Stages = aes_pkg::NumRounds + 1;

    logic [63:0] key_low_reg, key_high_reg;
    logic [Stages-1:0] valid_reg;
    aes_pkg::block_t state_reg [Stages];
    aes_pkg::block_t key_reg [Stages];
    aes_pkg::block_t init_key;
    logic [7:0] rcon [aes_pkg::NumRounds];

    assign busy = 1'b0;
    assign init_key = {key_high_reg, key_low_reg};
    assign rcon = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                    8'h1b, 8'h36};

    // key register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (aes_pkg::reg_idx_t'(cfg_index))
                aes_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                aes_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[Stages-2:0], start & ~busy};
    end

    // initial add round key stage
    always_ff @(posedge clk)
    begin
        state_reg[0] <= {plain_high, plain_low} ^ init_key;
        key_reg[0]   <= init_key;
    end

    // chain of round and key cells
    for (genvar g = 1; g < Stages; g++)
    begin : g_round
        aes_pkg::block_t rk;
        aes_key_cell u_key (
            .clk     (clk),
            .rcon    (rcon[g-1]),
            .key_in  (key_reg[g-1]),
            .key_out (key_reg[g])
        );
        // round key used combinationally from the previous key register
        always_comb
        begin
            logic [31:0] t;
            logic [31:0] w [4];
            t = {aes_pkg::SBOX[key_reg[g-1][103:96]],
                 aes_pkg::SBOX[key_reg[g-1][127:120]],
                 aes_pkg::SBOX[key_reg[g-1][119:112]],
                 aes_pkg::SBOX[key_reg[g-1][111:104]] ^ rcon[g-1]};
            w[0] = key_reg[g-1][31:0] ^ t;
            w[1] = key_reg[g-1][63:32] ^ w[0];
            w[2] = key_reg[g-1][95:64] ^ w[1];
            w[3] = key_reg[g-1][127:96] ^ w[2];
            rk = {w[3], w[2], w[1], w[0]};
        end
        aes_round_cell #(
            .LastRound (g == Stages - 1)
        ) u_round (
            .clk       (clk),
            .state_in  (state_reg[g-1]),
            .round_key (rk),
            .state_out (state_reg[g])
        );
    end

    assign done        = valid_reg[Stages-1];
    assign cipher_low  = state_reg[Stages-1][63:0];
    assign cipher_high = state_reg[Stages-1][127:64];

endmodule

FILE: design/aes128_encrypt_checker.sv
`include "assert_macros.svh"

// port-level checks for the encryption pipeline
module aes128_encrypt_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // no beat is ever refused
    `ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy)
    // a start beat taken outside reset produces a result once it has passed the valid chain
    `ASSERT_IMPL(a_latency, clk, rst_n, $past(start, 11) && $past(rst_n, 11), done)
    // no result without a matching earlier start beat
    `ASSERT_IMPL(a_no_extra, clk, rst_n, done, $past(start, 11))

endmodule

bind aes128_encrypt aes128_encrypt_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

FILE: test/aes128_encrypt_test.sv
module aes128_encrypt_test;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] plain_low;
    logic [63:0] plain_high;
    logic        done;
    logic [63:0] cipher_low;
    logic [63:0] cipher_high;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    aes128_encrypt DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .plain_low(plain_low),
        .plain_high(plain_high),
        .done(done),
        .cipher_low(cipher_low),
        .cipher_high(cipher_high),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } half_pair_t;

    // blocks waiting to be driven, ciphertexts waiting to come out
    half_pair_t plain_queue[$];
    half_pair_t cipher_queue[$];
    logic [63:0] key_lo_model;
    logic [63:0] key_hi_model;
    int          error_count;
    int          idle_pct;
    logic        driver_stop;

    function automatic logic [7:0] gmul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // full AES-128 encryption with inline key schedule
    function automatic half_pair_t aes_encrypt(input logic [63:0] klo, input logic [63:0] khi,
                                               input half_pair_t pt);
        logic [7:0] k[16];
        logic [7:0] s[16];
        logic [7:0] t[16];
        logic [7:0] w[4];
        logic [7:0] rcon;
        logic [7:0] a0, a1, a2, a3, sum;
        half_pair_t ct;
        rcon = 8'h01;
        for (int i = 0; i < 8; i++)
        begin
            k[i]     = klo[8*i +: 8];
            k[8 + i] = khi[8*i +: 8];
            s[i]     = pt.low[8*i +: 8] ^ klo[8*i +: 8];
            s[8 + i] = pt.high[8*i +: 8] ^ khi[8*i +: 8];
        end
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            // next round key
            w[0] = aes_pkg::SBOX[k[13]] ^ rcon;
            w[1] = aes_pkg::SBOX[k[14]];
            w[2] = aes_pkg::SBOX[k[15]];
            w[3] = aes_pkg::SBOX[k[12]];
            rcon = gmul2(rcon);
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                begin
                    k[4*c + r] = k[4*c + r] ^ w[r];
                    w[r] = k[4*c + r];
                end
            // sub bytes and shift rows
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[4*c + r] = aes_pkg::SBOX[s[4*((c + r) % 4) + r]];
            // mix columns except in the last round
            if (rnd != 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c + 1]; a2 = t[4*c + 2]; a3 = t[4*c + 3];
                    sum = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]     = a0 ^ sum ^ gmul2(a0 ^ a1);
                    t[4*c + 1] = a1 ^ sum ^ gmul2(a1 ^ a2);
                    t[4*c + 2] = a2 ^ sum ^ gmul2(a2 ^ a3);
                    t[4*c + 3] = a3 ^ sum ^ gmul2(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ k[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            ct.low[8*i +: 8]  = s[i];
            ct.high[8*i +: 8] = s[8 + i];
        end
        return ct;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    // driver: one beat per accepted start
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            plain_low  <= '0;
            plain_high <= '0;
        end
        else
        begin
            if (start && !busy)
                cipher_queue.push_back(aes_encrypt(key_lo_model, key_hi_model,
                                                   {plain_high, plain_low}));
            if ((!start || !busy) && !driver_stop)
            begin
                if (plain_queue.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start      <= 1'b1;
                    {plain_high, plain_low} <= plain_queue.pop_front();
                end
                else
                    start <= 1'b0;
            end
            else if (driver_stop && !busy)
                start <= 1'b0;
        end
    end

    // monitor: compare each done beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (cipher_queue.size() == 0)
            begin
                $display("unexpected ciphertext beat at %0t", $time);
                error_count++;
            end
            else
            begin
                half_pair_t want;
                want = cipher_queue.pop_front();
                if (cipher_low !== want.low)
                    report_mismatch("cipher_low", cipher_low, want.low);
                if (cipher_high !== want.high)
                    report_mismatch("cipher_high", cipher_high, want.high);
            end
        end
    end

    task automatic write_key(input aes_pkg::reg_idx_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == aes_pkg::REG_KEY_LOW)
            key_lo_model = value;
        else
            key_hi_model = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // run queued blocks until all ciphertexts are back and the pipe is empty
    task automatic drain();
        driver_stop = 1'b0;
        wait (plain_queue.size() == 0);
        @(posedge clk);
        while (start && busy)
            @(posedge clk);
        @(posedge clk);
        driver_stop = 1'b1;
        while (cipher_queue.size() != 0)
            @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    task automatic load_random(input int count);
        for (int i = 0; i < count; i++)
            plain_queue.push_back({rand64(), rand64()});
    endtask

    initial
    begin
        error_count  = 0;
        idle_pct     = 30;
        driver_stop  = 1'b1;
        key_lo_model = '0;
        key_hi_model = '0;
        cfg_we       = 1'b0;
        cfg_index    = aes_pkg::REG_KEY_LOW;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed blocks under the reset key of all zeros
        plain_queue.push_back({64'h0, 64'h0});
        plain_queue.push_back({64'hffffffffffffffff, 64'hffffffffffffffff});
        plain_queue.push_back({64'h0, 64'hffffffffffffffff});
        plain_queue.push_back({64'h8000000000000000, 64'h1});
        drain();

        // standard test vector key, then extreme keys
        write_key(aes_pkg::REG_KEY_LOW, 64'h0706050403020100);
        write_key(aes_pkg::REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
        plain_queue.push_back({64'hffeeddccbbaa9988, 64'h7766554433221100});
        plain_queue.push_back({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
        drain();
        write_key(aes_pkg::REG_KEY_LOW, 64'hffffffffffffffff);
        write_key(aes_pkg::REG_KEY_HIGH, 64'hffffffffffffffff);
        plain_queue.push_back({64'h0, 64'h0});
        plain_queue.push_back({64'hffffffffffffffff, 64'hffffffffffffffff});
        drain();
        write_key(aes_pkg::REG_KEY_LOW, 64'h0);
        plain_queue.push_back({64'h0123456789abcdef, 64'hfedcba9876543210});
        drain();

        // random phases: idle pressure in two of every three, a back-to-back stream in the third
        for (int ph = 0; ph < 12; ph++)
        begin
            write_key(aes_pkg::REG_KEY_LOW, rand64());
            write_key(aes_pkg::REG_KEY_HIGH, rand64());
            idle_pct = (ph % 3 == 2) ? 0 : 30;
            load_random(100);
            drain();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
